@@ sv/vector_angle_degrees_assert.svh @@
// Assertion helpers for the vector angle pipeline.
// Each use names the label, clock, active-low reset, antecedent and consequent.
`ifndef VECTOR_ANGLE_DEGREES_ASSERT_SVH
`define VECTOR_ANGLE_DEGREES_ASSERT_SVH

// Consequent checked in the same cycle
`define VAD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vector_angle_degrees: same-cycle check failed");

// Consequent checked in the following cycle
`define VAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vector_angle_degrees: next-cycle check failed");

`endif

@@ sv/vad_pkg.sv @@
`default_nettype none

package vad_pkg;

    // Defaults for the top-level parameters
    localparam int COORD_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF  = 16;

    // Fixed field widths
    localparam int IN_W    = 16;
    localparam int ANGLE_W = 16;

    // Fixed-point layout
    localparam int GUARD_BITS = 8;
    localparam int TABLE_LEN  = 24;
    localparam int Z_W        = 25;   // signed degrees, 16 fraction bits
    localparam int ZC_W       = 23;   // clamped first-quadrant angle

    localparam logic [ZC_W-1:0] DEG90_Q16 = 23'd5898240;

    // Angles in degrees, 7 fraction bits
    localparam logic [ANGLE_W-1:0] DEG0_Q7   = 16'd0;
    localparam logic [ANGLE_W-1:0] DEG90_Q7  = 16'd11520;
    localparam logic [ANGLE_W-1:0] DEG180_Q7 = 16'd23040;
    localparam logic [ANGLE_W-1:0] DEG270_Q7 = 16'd34560;
    localparam logic [ANGLE_W:0]   DEG360_Q7 = 17'd46080;

    // Per-transaction side information carried next to the CORDIC data
    typedef struct packed {
        logic                special;      // on an axis or at the origin
        logic [ANGLE_W-1:0]  special_val;  // result for the axis cases
        logic                x_neg;
        logic                y_neg;
    } t_vad_info;

    // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
    function automatic logic [Z_W-1:0] atan_q16(input logic [4:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 25'd2949120;
            5'd1:    v = 25'd1740967;
            5'd2:    v = 25'd919879;
            5'd3:    v = 25'd466945;
            5'd4:    v = 25'd234379;
            5'd5:    v = 25'd117304;
            5'd6:    v = 25'd58666;
            5'd7:    v = 25'd29335;
            5'd8:    v = 25'd14668;
            5'd9:    v = 25'd7334;
            5'd10:   v = 25'd3667;
            5'd11:   v = 25'd1833;
            5'd12:   v = 25'd917;
            5'd13:   v = 25'd458;
            5'd14:   v = 25'd229;
            5'd15:   v = 25'd115;
            5'd16:   v = 25'd57;
            5'd17:   v = 25'd29;
            5'd18:   v = 25'd14;
            5'd19:   v = 25'd7;
            5'd20:   v = 25'd4;
            5'd21:   v = 25'd2;
            5'd22:   v = 25'd1;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ sv/vector_angle_degrees.sv @@
`default_nettype none
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_vec_x, i_vec_y (signed 16)
// output    out        o_valid / i_stall    o_angle_deg (unsigned 16, deg x 128)
//
// One vector per clock, sustained while the output is not stalled. The stages
// are one fold stage, one CORDIC micro-rotation stage per iteration, and one
// stage for rounding and quadrant correction. Reset clears only the stage valid bits.
// Each stage advances whenever the stage after it is empty or moving, so
// bubbles squeeze out and the pipeline keeps filling behind a stalled result.
`include "vector_angle_degrees_assert.svh"

module vector_angle_degrees
    import vad_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ITERATIONS  = ITERATIONS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [IN_W-1:0]    i_vec_x,
    input  wire logic [IN_W-1:0]    i_vec_y,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [ANGLE_W-1:0]      o_angle_deg
);

    localparam int NI = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
    // guard bits plus headroom for CORDIC gain and sign
    localparam int W  = COORD_WIDTH + GUARD_BITS + 3;

    // Stage registers: index 0 holds the folded vector, index NI the last rotation
    logic                r_v    [0:NI];
    logic signed [W-1:0] r_x    [0:NI];
    logic signed [W-1:0] r_y    [0:NI];
    logic signed [Z_W-1:0] r_z  [0:NI];
    t_vad_info           r_info [0:NI];

    logic                r_out_valid;
    logic [ANGLE_W-1:0]  r_angle;

    logic                w_rdy  [0:NI+1];

    // Ready chain, from the output back to the input
    assign w_rdy[NI+1] = !r_out_valid || !i_stall;
    for (genvar k = 0; k <= NI; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end

    assign o_stall = !w_rdy[0];

    // Input coordinates, read as signed COORD_WIDTH-bit values, or zero-extended from IN_W bits if COORD_WIDTH is wider
    logic signed [W-1:0] w_x;
    logic signed [W-1:0] w_y;
    if (COORD_WIDTH <= IN_W) begin : g_narrow
        assign w_x = W'($signed(i_vec_x[COORD_WIDTH-1:0]));
        assign w_y = W'($signed(i_vec_y[COORD_WIDTH-1:0]));
    end else begin : g_wide
        assign w_x = W'({1'b0, i_vec_x});
        assign w_y = W'({1'b0, i_vec_y});
    end

    // Fold into the first quadrant and sort out the axis cases
    logic signed [W-1:0] n_x0;
    logic signed [W-1:0] n_y0;
    t_vad_info           n_info0;
    logic                w_x_zero;
    logic                w_y_zero;

    always_comb begin
        w_x_zero = (w_x == '0);
        w_y_zero = (w_y == '0);
        n_x0 = (w_x[W-1] ? -w_x : w_x) <<< GUARD_BITS;
        n_y0 = (w_y[W-1] ? -w_y : w_y) <<< GUARD_BITS;
        n_info0.x_neg   = w_x[W-1];
        n_info0.y_neg   = w_y[W-1];
        n_info0.special = w_x_zero || w_y_zero;
        if (w_y_zero && !w_x[W-1]) begin
            n_info0.special_val = DEG0_Q7;
        end else if (w_x_zero && !w_y[W-1]) begin
            n_info0.special_val = DEG90_Q7;
        end else if (w_y_zero) begin
            n_info0.special_val = DEG180_Q7;
        end else begin
            n_info0.special_val = DEG270_Q7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_rdy[0]) begin
            r_v[0] <= i_valid;
        end
        if (w_rdy[0] && i_valid) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= '0;
            r_info[0] <= n_info0;
        end
    end

    // One CORDIC vectoring micro-rotation per stage
    for (genvar i = 0; i < NI; i++) begin : g_iter
        logic signed [W-1:0]   n_x;
        logic signed [W-1:0]   n_y;
        logic signed [Z_W-1:0] n_z;
        logic signed [Z_W-1:0] w_atan;

        assign w_atan = $signed(atan_q16(5'(i)));

        always_comb begin
            if (!r_y[i][W-1]) begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + w_atan;
            end else begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - w_atan;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (w_rdy[i+1]) begin
                r_v[i+1] <= r_v[i];
            end
            if (w_rdy[i+1] && r_v[i]) begin
                r_x[i+1]    <= n_x;
                r_y[i+1]    <= n_y;
                r_z[i+1]    <= n_z;
                r_info[i+1] <= r_info[i];
            end
        end
    end

    // Clamp, round to 7 fraction bits, map to the full circle
    logic [ZC_W-1:0]     w_zc;
    logic [ZC_W:0]       w_zr;
    logic [ANGLE_W-1:0]  w_a;
    logic [ANGLE_W:0]    w_full;
    logic [ANGLE_W-1:0]  n_angle;
    t_vad_info           w_fin;

    always_comb begin
        w_fin = r_info[NI];
        if (r_z[NI][Z_W-1]) begin
            w_zc = '0;
        end else if (r_z[NI] > $signed(Z_W'(DEG90_Q16))) begin
            w_zc = DEG90_Q16;
        end else begin
            w_zc = r_z[NI][ZC_W-1:0];
        end
        w_zr = {1'b0, w_zc} + (ZC_W+1)'(256);
        w_a  = ANGLE_W'(w_zr[ZC_W:9]);
        if (!w_fin.x_neg && !w_fin.y_neg) begin
            w_full = {1'b0, w_a};
        end else if (w_fin.x_neg && !w_fin.y_neg) begin
            w_full = {1'b0, DEG180_Q7} - {1'b0, w_a};
        end else if (w_fin.x_neg) begin
            w_full = {1'b0, DEG180_Q7} + {1'b0, w_a};
        end else begin
            w_full = DEG360_Q7 - {1'b0, w_a};
        end
        if (w_fin.special) begin
            n_angle = w_fin.special_val;
        end else if (w_full >= DEG360_Q7) begin
            n_angle = DEG0_Q7;
        end else begin
            n_angle = w_full[ANGLE_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy[NI+1]) begin
            r_out_valid <= r_v[NI];
        end
        if (w_rdy[NI+1] && r_v[NI]) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_angle_deg = r_angle;

    // Results never reach a full turn
    `VAD_ASSERT_NOW(a_angle_range, i_clk, i_rst_n, r_out_valid, r_angle < DEG360_Q7[ANGLE_W-1:0])
    // An accepted transaction lands in the fold stage
    `VAD_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_valid && !o_stall, r_v[0])
    // Off the axes the folded vector lies strictly inside the first quadrant
    `VAD_ASSERT_NOW(a_fold_positive, i_clk, i_rst_n, r_v[0] && !r_info[0].special,
                    (r_x[0] > 0) && (r_y[0] > 0))
    // An empty output register never back-pressures the input
    `VAD_ASSERT_NOW(a_empty_no_stall, i_clk, i_rst_n, !r_out_valid, !o_stall)

endmodule

`default_nettype wire
